// ----- rtl/core/rmsm_pkg.sv -----
package rmsm_pkg;

   // Field widths
   localparam int SAMPLE_W   = 10;
   localparam int WLEN_W     = 9;
   localparam int OFFSET_W   = 10;
   localparam int GAIN_W     = 16;
   localparam int VOLTS_W    = 16;
   localparam int COUNTS_W   = 14;
   localparam int SQUARE_W   = 2 * SAMPLE_W;
   localparam int SUM_W      = 29;
   localparam int PROD_W     = COUNTS_W + GAIN_W;

   // Port widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ZERO_OFFSET   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_VOLTS_GAIN    = 2'd2;

   // Register reset values
   localparam logic [WLEN_W-1:0]   WINDOW_LENGTH_RST = 9'd174;
   localparam logic [OFFSET_W-1:0] ZERO_OFFSET_RST   = 10'd512;
   localparam logic [GAIN_W-1:0]   VOLTS_GAIN_RST    = 16'd5668;

   // Window size limit
   localparam int WINDOW_MAX_DEF = 256;

   // Divide / square root datapath
   localparam int MEAN_SHIFT  = 8;
   localparam int VOLTS_SHIFT = 12;
   localparam int WORK_W      = 1 + SUM_W + MEAN_SHIFT;   // even count of bits for root pairs
   localparam int DIV_STEPS   = SUM_W + MEAN_SHIFT;
   localparam int SQRT_STEPS  = WORK_W / 2;
   localparam int ROOT_W      = SQRT_STEPS;
   localparam int SQ_REM_W    = ROOT_W + 2;
   localparam int STEP_W      = 6;

endpackage

// ----- rtl/core/windowed_rms_voltage_meter.sv -----
// Channel   Dir  Words carry
// req_      in   req_tdata[9:0] sample_code
// rsp_      out  rsp_tdata[15:0] rms_volts, [29:16] rms_counts
// csr_      in   index 0 window_length, 1 zero_offset, 2 volts_gain
//
// A sample that does not close a window is taken, squared and accumulated.
// A closing sample is taken and squared, then passes through the shared
// subtractor unit (37 restoring divide steps, 19 root steps, then done and clamp),
// then one multiply and the output load.
// Reset is synchronous and clears the sum, count, sequencer and output valid.
// A stalled result is held in the output register; a further window end waits for it.
module windowed_rms_voltage_meter import rmsm_pkg::*; #(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [9:0] sample_code
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [15:0] rms_volts, [29:16] rms_counts
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int LEN_W = $clog2(WINDOW_MAX + 1);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_SQR  = 6'b000010,
      S_ACC  = 6'b000100,
      S_CALC = 6'b001000,
      S_MUL  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [WLEN_W-1:0]      window_length_ff;
   logic [OFFSET_W-1:0]    zero_offset_ff;
   logic [GAIN_W-1:0]      volts_gain_ff;
   logic [SAMPLE_W-1:0]    dev_ff;
   logic [SQUARE_W-1:0]    square_ff;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [LEN_W-1:0]       count_ff, count_in;
   logic [COUNTS_W-1:0]    counts_ff;
   logic [PROD_W-1:0]      prod_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VOLTS_W-1:0]     rsp_volts_ff;
   logic [COUNTS_W-1:0]    rsp_counts_ff;

   logic [SAMPLE_W-1:0]    sample;
   logic [SAMPLE_W-1:0]    dev;
   logic [LEN_W-1:0]       len;
   logic [SUM_W:0]         sum_wide;
   logic [SUM_W-1:0]       sum_next;
   logic [LEN_W:0]         count_inc;
   logic                   window_end;
   logic                   unit_start;
   logic                   unit_done;
   logic [ROOT_W-1:0]      unit_root;
   logic [PROD_W-VOLTS_SHIFT-1:0] volts_full;
   logic                   load_out;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_LENGTH_RST;
         zero_offset_ff   <= ZERO_OFFSET_RST;
         volts_gain_ff    <= VOLTS_GAIN_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_WINDOW_LENGTH: window_length_ff <= csr_wdata[WLEN_W-1:0];
            CSR_ZERO_OFFSET:   zero_offset_ff   <= csr_wdata[OFFSET_W-1:0];
            CSR_VOLTS_GAIN:    volts_gain_ff    <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the window length to 1 .. WINDOW_MAX
   always_comb begin
      if (window_length_ff == '0)
         len = LEN_W'(1);
      else if (32'(window_length_ff) > WINDOW_MAX)
         len = LEN_W'(WINDOW_MAX);
      else
         len = LEN_W'(window_length_ff);
   end

   // Absolute deviation from the zero code
   assign sample = req_tdata[SAMPLE_W-1:0];
   assign dev    = (sample >= zero_offset_ff) ? (sample - zero_offset_ff)
                                              : (zero_offset_ff - sample);

   // Saturating accumulate and window count
   assign sum_wide   = {1'b0, sum_ff} + (SUM_W + 1)'(square_ff);
   assign sum_next   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
   assign count_inc  = {1'b0, count_ff} + (LEN_W + 1)'(1);
   assign window_end = (count_inc >= {1'b0, len});

   assign volts_full = prod_ff[PROD_W-1:VOLTS_SHIFT];
   assign load_out   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   assign unit_start = (state_ff == S_ACC) && window_end;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_SQR;
         S_SQR:  state_in = S_ACC;
         S_ACC: begin
            if (window_end) begin
               sum_in   = '0;
               count_in = '0;
               state_in = S_CALC;
            end else begin
               sum_in   = sum_next;
               count_in = count_inc[LEN_W-1:0];
               state_in = S_IDLE;
            end
         end
         S_CALC: if (unit_done) state_in = S_MUL;
         S_MUL:  state_in = S_OUT;
         S_OUT:  if (load_out) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Output valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid)
         dev_ff <= dev;
      if (state_ff == S_SQR)
         square_ff <= SQUARE_W'(dev_ff) * SQUARE_W'(dev_ff);
      if (state_ff == S_CALC && unit_done)
         counts_ff <= (|unit_root[ROOT_W-1:COUNTS_W]) ? {COUNTS_W{1'b1}}
                                                      : unit_root[COUNTS_W-1:0];
      if (state_ff == S_MUL)
         prod_ff <= PROD_W'(counts_ff) * PROD_W'(volts_gain_ff);
      if (load_out) begin
         rsp_counts_ff <= counts_ff;
         rsp_volts_ff  <= (|volts_full[PROD_W-VOLTS_SHIFT-1:VOLTS_W]) ? {VOLTS_W{1'b1}}
                                                       : volts_full[VOLTS_W-1:0];
      end
   end

   // Shared divide and square root unit
   rmsm_divsqrt #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_divsqrt (
      .clock (clock),
      .reset (reset),
      .start (unit_start),
      .sum   (sum_next),
      .len   (len),
      .done  (unit_done),
      .root  (unit_root)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_counts_ff, rsp_volts_ff});

endmodule

// ----- rtl/core/rmsm_divsqrt.sv -----
module rmsm_divsqrt import rmsm_pkg::*; #(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [SUM_W-1:0]                  sum,
   input  logic [$clog2(WINDOW_MAX+1)-1:0]   len,
   output logic                              done,
   output logic [ROOT_W-1:0]                 root
);

   localparam int LEN_W = $clog2(WINDOW_MAX + 1);
   localparam int SUB_W = (LEN_W + 1 > SQ_REM_W) ? LEN_W + 1 : SQ_REM_W;
   localparam int REM_W = SUB_W - 1;

   typedef enum logic [2:0] {
      U_IDLE = 3'b001,
      U_DIV  = 3'b010,
      U_SQRT = 3'b100
   } unit_state_type;

   unit_state_type       state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [WORK_W-1:0]    work_ff, work_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic                 done_ff, done_in;

   logic [SUB_W-1:0]     sub_a;
   logic [SUB_W-1:0]     sub_b;
   logic [SUB_W:0]       diff;
   logic                 ge;

   // Shared compare-and-subtract unit: divisor trial or root trial
   always_comb begin
      case (state_ff)
         U_DIV: begin
            sub_a = SUB_W'({rem_ff[LEN_W-1:0], work_ff[WORK_W-2]});
            sub_b = SUB_W'(len_ff);
         end
         U_SQRT: begin
            sub_a = SUB_W'({rem_ff[SQ_REM_W-3:0], work_ff[WORK_W-1:WORK_W-2]});
            sub_b = SUB_W'({root_ff, 2'b01});
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
      diff = {1'b0, sub_a} - {1'b0, sub_b};
      ge   = ~diff[SUB_W];
   end

   // Sequence: one quotient bit per cycle, then one root bit per cycle
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      len_in   = len_ff;
      done_in  = 1'b0;
      case (state_ff)
         U_IDLE: begin
            if (start) begin
               work_in  = {1'b0, sum, MEAN_SHIFT'(0)};
               len_in   = len;
               rem_in   = '0;
               step_in  = '0;
               state_in = U_DIV;
            end
         end
         U_DIV: begin
            rem_in  = ge ? REM_W'(diff[SUB_W-1:0]) : REM_W'(sub_a);
            work_in = {1'b0, work_ff[WORK_W-3:0], ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = U_SQRT;
            end
         end
         U_SQRT: begin
            rem_in  = ge ? REM_W'(diff[SUB_W-1:0]) : REM_W'(sub_a);
            root_in = {root_ff[ROOT_W-2:0], ge};
            work_in = {work_ff[WORK_W-3:0], 2'b00};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               done_in  = 1'b1;
               state_in = U_IDLE;
            end
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      len_ff  <= len_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- rtl/core/rmsm_checker.sv -----
module rmsm_checker import rmsm_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata
);

   // Reset leaves the block ready with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_tready && !rsp_tvalid))
      else $error("block not idle after reset");

   // One sample at a time: ready drops right after a word is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready held after an accepted word");

   // Zero counts always scale to zero volts
   a_zero_volts: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[29:16] == '0) |-> (rsp_tdata[15:0] == '0))
      else $error("nonzero volts for zero counts");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed or dropped");

endmodule

bind windowed_rms_voltage_meter rmsm_checker u_rmsm_checker (.*);
